/* rtl/rpp_pkg.sv */
// ----------------------------------------------------------------------------
// rpp_pkg
// Shared types and constants for the 15-bit RLE pixel packer.
// ----------------------------------------------------------------------------
package rpp_pkg;

  localparam int unsigned CODE_W     = 15;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [CODE_W-1:0] RUN_LIMIT = 15'h7FFF;

  // default quantization: 5/5/5 packed as R:G:B
  localparam int unsigned DEF_RED_MAX     = 31;
  localparam int unsigned DEF_GREEN_MAX   = 31;
  localparam int unsigned DEF_BLUE_MAX    = 31;
  localparam int unsigned DEF_RED_SHIFT   = 10;
  localparam int unsigned DEF_GREEN_SHIFT = 5;
  localparam int unsigned DEF_BLUE_SHIFT  = 0;

  // one request from front to back: an optional closed run, then an
  // optional flushed run on the last pixel of the image
  typedef struct packed {
    logic              close_vld;
    logic [CODE_W-1:0] close_code;
    logic [CODE_W-1:0] close_len;
    logic              flush_vld;
    logic [CODE_W-1:0] flush_code;
    logic [CODE_W-1:0] flush_len;
  } rpp_entry_t;

  typedef enum logic {
    SEG_CLOSE,
    SEG_FLUSH
  } rpp_seg_e;

endpackage

/* rtl/rpp_front.sv */
// ----------------------------------------------------------------------------
// rpp_front
// Quantizes each pixel to a color code and tracks the open run.
// ----------------------------------------------------------------------------
module rpp_front #(
  parameter int unsigned RED_MAX     = rpp_pkg::DEF_RED_MAX,
  parameter int unsigned GREEN_MAX   = rpp_pkg::DEF_GREEN_MAX,
  parameter int unsigned BLUE_MAX    = rpp_pkg::DEF_BLUE_MAX,
  parameter int unsigned RED_SHIFT   = rpp_pkg::DEF_RED_SHIFT,
  parameter int unsigned GREEN_SHIFT = rpp_pkg::DEF_GREEN_SHIFT,
  parameter int unsigned BLUE_SHIFT  = rpp_pkg::DEF_BLUE_SHIFT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [rpp_pkg::CHAN_W-1:0]  pixel_red_i,
  input  logic [rpp_pkg::CHAN_W-1:0]  pixel_green_i,
  input  logic [rpp_pkg::CHAN_W-1:0]  pixel_blue_i,
  input  logic                        final_pixel_i,
  output logic                        push_o,
  output rpp_pkg::rpp_entry_t         entry_o
);
  import rpp_pkg::*;

  // floor(v * mx / 255): product fits 13 bits, so (x + (x >> 8) + 1) >> 8
  function automatic logic [CODE_W-1:0] quant(input logic [CHAN_W-1:0] v,
                                              input logic [4:0] mx,
                                              input logic [3:0] sh);
    logic [13:0] prod;
    logic [13:0] sum;
    logic [4:0]  q;
    prod = 14'(v) * 14'(mx);
    sum  = prod + (prod >> 8) + 14'd1;
    q    = sum[12:8];
    return CODE_W'(q) << sh;
  endfunction

  logic              run_open_q, run_open_d;
  logic [CODE_W-1:0] run_code_q, run_code_d;
  logic [CODE_W-1:0] run_len_q, run_len_d;

  logic [CODE_W-1:0] code;
  logic              extend, close;
  logic [CODE_W-1:0] code_new, len_new;

  always_comb begin
    code = quant(pixel_red_i,   5'(RED_MAX),   4'(RED_SHIFT))
         | quant(pixel_green_i, 5'(GREEN_MAX), 4'(GREEN_SHIFT))
         | quant(pixel_blue_i,  5'(BLUE_MAX),  4'(BLUE_SHIFT));

    extend   = run_open_q && (code == run_code_q) && (run_len_q != RUN_LIMIT);
    close    = run_open_q && !extend;
    code_new = extend ? run_code_q : code;
    len_new  = extend ? run_len_q + CODE_W'(1) : CODE_W'(1);

    run_open_d = run_open_q;
    run_code_d = run_code_q;
    run_len_d  = run_len_q;
    if (accept_i) begin
      if (final_pixel_i) begin
        run_open_d = 1'b0;
        run_code_d = '0;
        run_len_d  = '0;
      end else begin
        run_open_d = 1'b1;
        run_code_d = code_new;
        run_len_d  = len_new;
      end
    end

    push_o             = accept_i && (close || final_pixel_i);
    entry_o.close_vld  = close;
    entry_o.close_code = run_code_q;
    entry_o.close_len  = run_len_q;
    entry_o.flush_vld  = final_pixel_i;
    entry_o.flush_code = code_new;
    entry_o.flush_len  = len_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      run_code_q <= '0;
      run_len_q  <= '0;
    end else begin
      run_open_q <= run_open_d;
      run_code_q <= run_code_d;
      run_len_q  <= run_len_d;
    end
  end

endmodule

/* rtl/rpp_fifo.sv */
// ----------------------------------------------------------------------------
// rpp_fifo
// Short request queue between the run tracker and the word emitter.
// ----------------------------------------------------------------------------
module rpp_fifo #(
  parameter int unsigned DEPTH = rpp_pkg::FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rpp_pkg::rpp_entry_t wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rpp_pkg::rpp_entry_t rdata_o
);
  import rpp_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rpp_entry_t         mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == CNT_W'(DEPTH));
    valid_o = (cnt_q != '0);
    rdata_o = mem_q[rd_ptr_q];
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end

    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* rtl/rpp_back.sv */
// ----------------------------------------------------------------------------
// rpp_back
// Expands queued run requests into header and code words, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module rpp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fifo_valid_i,
  input  rpp_pkg::rpp_entry_t         fifo_data_i,
  output logic                        fifo_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rpp_pkg::WORD_W-1:0]  code_word_o,
  output logic                        is_header_o,
  output logic                        item_done_o,
  output logic                        image_done_o
);
  import rpp_pkg::*;

  logic              have_q, have_d;
  rpp_entry_t        ent_q, ent_d;
  rpp_seg_e          seg_q, seg_d;
  logic              hdr_done_q, hdr_done_d;

  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic              hdr_q, hdr_d;
  logic              item_q, item_d;
  logic              image_q, image_d;

  logic              load, need_hdr, seg_last, ent_last;
  logic [CODE_W-1:0] cur_code, cur_len;

  always_comb begin
    load     = have_q && (!out_valid_q || !out_stall_i);
    cur_code = (seg_q == SEG_CLOSE) ? ent_q.close_code : ent_q.flush_code;
    cur_len  = (seg_q == SEG_CLOSE) ? ent_q.close_len  : ent_q.flush_len;
    need_hdr = (|cur_len[CODE_W-1:1]) && !hdr_done_q;
    seg_last = !need_hdr;
    ent_last = seg_last && ((seg_q == SEG_FLUSH) || !ent_q.flush_vld);

    fifo_pop_o = fifo_valid_i && (!have_q || (load && ent_last));

    have_d     = have_q;
    ent_d      = ent_q;
    seg_d      = seg_q;
    hdr_done_d = hdr_done_q;
    if (load) begin
      hdr_done_d = need_hdr;
      if (ent_last) begin
        have_d = 1'b0;
      end else if (seg_last) begin
        seg_d = SEG_FLUSH;
      end
    end
    if (fifo_pop_o) begin
      have_d     = 1'b1;
      ent_d      = fifo_data_i;
      seg_d      = fifo_data_i.close_vld ? SEG_CLOSE : SEG_FLUSH;
      hdr_done_d = 1'b0;
    end

    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    hdr_d       = hdr_q;
    item_d      = item_q;
    image_d     = image_q;
    if (load) begin
      out_valid_d = 1'b1;
      word_d      = need_hdr ? {1'b1, cur_len} : {1'b0, cur_code};
      hdr_d       = need_hdr;
      item_d      = ent_last;
      image_d     = ent_last && ent_q.flush_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      seg_q       <= SEG_CLOSE;
      hdr_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      have_q      <= have_d;
      seg_q       <= seg_d;
      hdr_done_q  <= hdr_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    word_q  <= word_d;
    hdr_q   <= hdr_d;
    item_q  <= item_d;
    image_q <= image_d;
  end

  assign out_valid_o  = out_valid_q;
  assign code_word_o  = word_q;
  assign is_header_o  = hdr_q;
  assign item_done_o  = item_q;
  assign image_done_o = image_q;

endmodule

/* rtl/rle_pixel_packer_15bit.sv */
// ----------------------------------------------------------------------------
// rle_pixel_packer_15bit
// Run-length packer: RGB pixels in, 15-bit color codes and run headers out.
// ----------------------------------------------------------------------------
// Throughput: one pixel and one word per cycle when neither side stalls.
// The first word of a pixel passes in turn through
//   the request queue, the emitter and the output register.
// Input stalls only while the 4-deep request queue is full.
// Reset clears the open run, the queue and the output register.
module rle_pixel_packer_15bit #(
  parameter int unsigned RED_MAX     = rpp_pkg::DEF_RED_MAX,
  parameter int unsigned GREEN_MAX   = rpp_pkg::DEF_GREEN_MAX,
  parameter int unsigned BLUE_MAX    = rpp_pkg::DEF_BLUE_MAX,
  parameter int unsigned RED_SHIFT   = rpp_pkg::DEF_RED_SHIFT,
  parameter int unsigned GREEN_SHIFT = rpp_pkg::DEF_GREEN_SHIFT,
  parameter int unsigned BLUE_SHIFT  = rpp_pkg::DEF_BLUE_SHIFT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rpp_pkg::CHAN_W-1:0]  pixel_red_i,
  input  logic [rpp_pkg::CHAN_W-1:0]  pixel_green_i,
  input  logic [rpp_pkg::CHAN_W-1:0]  pixel_blue_i,
  input  logic                        final_pixel_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rpp_pkg::WORD_W-1:0]  code_word_o,
  output logic                        is_header_o,
  output logic                        item_done_o,
  output logic                        image_done_o
);
  import rpp_pkg::*;

  logic       accept;
  logic       push, full, fifo_valid, fifo_pop;
  rpp_entry_t push_entry, pop_entry;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  rpp_front #(
    .RED_MAX     (RED_MAX),
    .GREEN_MAX   (GREEN_MAX),
    .BLUE_MAX    (BLUE_MAX),
    .RED_SHIFT   (RED_SHIFT),
    .GREEN_SHIFT (GREEN_SHIFT),
    .BLUE_SHIFT  (BLUE_SHIFT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .final_pixel_i (final_pixel_i),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  rpp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .rdata_o (pop_entry)
  );

  rpp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (pop_entry),
    .fifo_pop_o   (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_word_o  (code_word_o),
    .is_header_o  (is_header_o),
    .item_done_o  (item_done_o),
    .image_done_o (image_done_o)
  );

endmodule

/* tb/sv/rle_pixel_packer_15bit_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pixel_packer_15bit_checker
// Watches both channels of the RLE pixel packer. Every accepted pixel goes
// through a local run tracker that queues the words the pixel should produce.
// Every accepted word is compared with the oldest queued word.
// ----------------------------------------------------------------------------
module rle_pixel_packer_15bit_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [rpp_pkg::CHAN_W-1:0] pixel_red_i,
  input  logic [rpp_pkg::CHAN_W-1:0] pixel_green_i,
  input  logic [rpp_pkg::CHAN_W-1:0] pixel_blue_i,
  input  logic                       final_pixel_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [rpp_pkg::WORD_W-1:0] code_word_i,
  input  logic                       is_header_i,
  input  logic                       item_done_i,
  input  logic                       image_done_i,
  output int                         error_count_o,
  output int                         pending_o
);
  import rpp_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              header;
    logic              pixel_end;
    logic              image_end;
  } packed_word_t;

  packed_word_t      pending_words[$];
  logic              run_active;
  logic [CODE_W-1:0] run_color;
  logic [CODE_W-1:0] run_count;
  int                n_errors;

  function automatic logic [CODE_W-1:0] quantize_channel(logic [CHAN_W-1:0] level,
                                                          int unsigned max_level,
                                                          int unsigned shift);
    int unsigned scaled;
    scaled = 32'(level);
    scaled = ((scaled * max_level) / 255) << shift;
    return scaled[CODE_W-1:0];
  endfunction

  function automatic packed_word_t make_word(logic [WORD_W-1:0] word, logic header);
    packed_word_t w;
    w.word      = word;
    w.header    = header;
    w.pixel_end = 1'b0;
    w.image_end = 1'b0;
    return w;
  endfunction

  // words for the open run: header only when it spans two or more pixels
  task automatic close_run();
    if (run_count >= CODE_W'(2)) begin
      pending_words.push_back(make_word({1'b1, run_count}, 1'b1));
    end
    pending_words.push_back(make_word({1'b0, run_color}, 1'b0));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    packed_word_t      head;
    logic [CODE_W-1:0] color;
    int                first_new;
    if (!rst_ni) begin
      run_active = 1'b0;
      run_color  = '0;
      run_count  = '0;
      n_errors   = 0;
      pending_words.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word: code_word %04h is_header %0b", code_word_i, is_header_i);
          n_errors++;
        end else begin
          head = pending_words.pop_front();
          if (code_word_i !== head.word) begin
            $error("code_word: expected %04h, got %04h", head.word, code_word_i);
            n_errors++;
          end
          if (is_header_i !== head.header) begin
            $error("is_header: expected %0b, got %0b", head.header, is_header_i);
            n_errors++;
          end
          if (item_done_i !== head.pixel_end) begin
            $error("item_done: expected %0b, got %0b", head.pixel_end, item_done_i);
            n_errors++;
          end
          if (image_done_i !== head.image_end) begin
            $error("image_done: expected %0b, got %0b", head.image_end, image_done_i);
            n_errors++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        first_new = pending_words.size();
        color = quantize_channel(pixel_red_i, DEF_RED_MAX, DEF_RED_SHIFT)
              | quantize_channel(pixel_green_i, DEF_GREEN_MAX, DEF_GREEN_SHIFT)
              | quantize_channel(pixel_blue_i, DEF_BLUE_MAX, DEF_BLUE_SHIFT);
        // a full run is closed even when the color matches
        if (run_active && color == run_color && run_count < RUN_LIMIT) begin
          run_count = run_count + CODE_W'(1);
        end else begin
          if (run_active) close_run();
          run_active = 1'b1;
          run_color  = color;
          run_count  = CODE_W'(1);
        end
        if (final_pixel_i) begin
          close_run();
          run_active = 1'b0;
          run_color  = '0;
          run_count  = '0;
        end
        if (pending_words.size() > first_new) begin
          head = pending_words[pending_words.size()-1];
          head.pixel_end = 1'b1;
          head.image_end = final_pixel_i;
          pending_words[pending_words.size()-1] = head;
        end
      end

      error_count_o <= n_errors;
      pending_o     <= pending_words.size();
    end
  end

endmodule

/* tb/sv/rle_pixel_packer_15bit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_pixel_packer_15bit_test
// Pixel stimulus for the RLE packer: directed corner cases, then random
// runs under several idle and stall mixes.
// ----------------------------------------------------------------------------
module rle_pixel_packer_15bit_test;
  import rpp_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 80;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [CHAN_W-1:0] pixel_red_i   = '0;
  logic [CHAN_W-1:0] pixel_green_i = '0;
  logic [CHAN_W-1:0] pixel_blue_i  = '0;
  logic              final_pixel_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [WORD_W-1:0] code_word_o;
  logic              is_header_o;
  logic              item_done_o;
  logic              image_done_o;

  int error_count;
  int words_pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_ticket    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  rle_pixel_packer_15bit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_red_i  (pixel_red_i),
    .pixel_green_i(pixel_green_i),
    .pixel_blue_i (pixel_blue_i),
    .final_pixel_i(final_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_word_o  (code_word_o),
    .is_header_o  (is_header_o),
    .item_done_o  (item_done_o),
    .image_done_o (image_done_o)
  );

  rle_pixel_packer_15bit_checker word_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .pixel_red_i  (pixel_red_i),
    .pixel_green_i(pixel_green_i),
    .pixel_blue_i (pixel_blue_i),
    .final_pixel_i(final_pixel_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_word_i  (code_word_o),
    .is_header_i  (is_header_o),
    .item_done_i  (item_done_o),
    .image_done_i (image_done_o),
    .error_count_o(error_count),
    .pending_o    (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus a long hold whenever the ticket moves
  always @(posedge clk_i) begin
    if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_pixel(input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                            input logic [CHAN_W-1:0] blue, input logic image_end);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    pixel_red_i   <= red;
    pixel_green_i <= green;
    pixel_blue_i  <= blue;
    final_pixel_i <= image_end;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // mostly runs of one color with jitter in the low bits, some lone noise
  task automatic random_stream(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       run_len;
    logic              close_image;
    logic [CHAN_W-1:0] base_r, base_g, base_b;
    logic [CHAN_W-1:0] r, g, b;
    sent = 0;
    while (sent < n_items) begin
      base_r = CHAN_W'($urandom);
      base_g = CHAN_W'($urandom);
      base_b = CHAN_W'($urandom);
      if ($urandom_range(4) == 0) begin
        push_pixel(base_r, base_g, base_b, $urandom_range(15) == 0);
        sent++;
      end else begin
        run_len     = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        close_image = ($urandom_range(5) == 0);
        for (int k = 0; k < run_len; k++) begin
          r = base_r;
          g = base_g;
          b = base_b;
          if ($urandom_range(3) == 0) begin
            r[0] = r[0] ^ 1'($urandom_range(1));
            g[0] = g[0] ^ 1'($urandom_range(1));
            b[0] = b[0] ^ 1'($urandom_range(1));
          end
          push_pixel(r, g, b, close_image && (k == run_len - 1));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone pixel, then a flushed run of four
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    // each color after the first closes the previous single-pixel run
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
    // different bytes: the first two share a quantized code, the third does not
    push_pixel(8'h08, 8'h08, 8'h08, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h09, 8'h09, 8'h09, 1'b1);
    push_pixel(8'hFE, 8'h7F, 8'h80, 1'b0);
    push_pixel(8'h01, 8'h00, 8'hFF, 1'b0);
    push_pixel(8'h01, 8'h00, 8'hFF, 1'b0);
    // final pixel with a different color: close and flush together
    push_pixel(8'h80, 8'h55, 8'hAA, 1'b1);
    // next image after the flush starts clean
    push_pixel(8'h80, 8'h55, 8'hAA, 1'b1);

    // back-pressure: output held while the sender keeps pushing
    hold_ticket++;
    random_stream(40);

    random_stream(100);
    send_idle_pct  = 83;
    recv_stall_pct = 0;
    random_stream(100);
    send_idle_pct  = 0;
    recv_stall_pct = 83;
    random_stream(100);
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    random_stream(100);
    push_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), 1'b1);
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (words_pending != 0);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
